### src/wrdb_pkg.sv
// Shared constants, types and the fractional-decade table for the windowed RMS dB meter.
package wrdb_pkg;

	localparam int MAX_WINDOW_LENGTH_DEF = 1024;

	localparam int WL_W  = 11;
	localparam int WPF_W = 8;
	localparam int DB_W  = 8;
	localparam int CNT_W = 8;
	localparam int SAMPLE_W = 16;
	localparam int SQ_W  = 31;
	localparam int TP_W  = 20;
	localparam int FRAC_SHIFT = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_PER_FRAME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD_DB = 2'd2;

	localparam logic [WL_W-1:0]         WINDOW_LENGTH_RST     = 11'd200;
	localparam logic [WPF_W-1:0]        WINDOWS_PER_FRAME_RST = 8'd80;
	localparam logic signed [DB_W-1:0]  PEAK_THRESHOLD_RST    = 8'sd75;

	localparam logic signed [DB_W-1:0] LEVEL_FLOOR = -8'sd24;
	localparam logic signed [DB_W-1:0] LEVEL_CEIL  = 8'sd90;
	localparam logic [DB_W-1:0] M_CEIL  = 8'd90;
	localparam logic [DB_W-1:0] M_FLOOR = 8'd24;
	localparam logic [DB_W-1:0] DECADE_STEP = 8'd10;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] FRAC_LAST = 4'd9;

	typedef struct packed {
		logic [WPF_W-1:0]        windows_per_frame;
		logic signed [DB_W-1:0]  peak_threshold_db;
	} wrdb_frame_cfg_t;

	// round(10^(i/10) * 2^16)
	function automatic logic [TP_W-1:0] tenth_pow(input logic [3:0] i);
		logic [TP_W-1:0] c;
		unique case (i)
			4'd0: c = 20'd65536;
			4'd1: c = 20'd82505;
			4'd2: c = 20'd103868;
			4'd3: c = 20'd130762;
			4'd4: c = 20'd164619;
			4'd5: c = 20'd207243;
			4'd6: c = 20'd260904;
			4'd7: c = 20'd328458;
			4'd8: c = 20'd413504;
			4'd9: c = 20'd520571;
			default: c = 20'd65536;
		endcase
		return c;
	endfunction

endpackage

### src/wrdb_queue.sv
// Short FIFO of finished window sums between the accumulator and the log unit.
module wrdb_queue #(
	parameter int WIDTH = 52
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [WIDTH-1:0]                  push_data,
	input  logic                              pop,
	output logic                              head_valid,
	output logic [WIDTH-1:0]                  head_data,
	output logic [wrdb_pkg::QUEUE_CNT_W-1:0]  count
);
	import wrdb_pkg::*;

	logic [WIDTH-1:0]       entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_pop;

	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/wrdb_front.sv
// Sample intake: square each sample, accumulate over a window, hand off window sums.
module wrdb_front #(
	parameter int MAX_WINDOW_LENGTH = wrdb_pkg::MAX_WINDOW_LENGTH_DEF,
	parameter int LEN_W = $clog2(MAX_WINDOW_LENGTH + 1),
	parameter int SUM_W = wrdb_pkg::SQ_W - 1 + LEN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [wrdb_pkg::SAMPLE_W-1:0] sample,
	input  logic [wrdb_pkg::WL_W-1:0]           window_length,
	input  logic [wrdb_pkg::QUEUE_CNT_W-1:0]    q_count,
	output logic                                push,
	output logic [SUM_W-1:0]                    push_sum,
	output logic [LEN_W-1:0]                    push_len
);
	import wrdb_pkg::*;

	logic                    v_s1;
	logic [SQ_W-1:0]         sq_s1;
	logic [SUM_W-1:0]        sum_q;
	logic [LEN_W-1:0]        idx_q;
	logic signed [2*SAMPLE_W-1:0] prod;
	logic [SUM_W-1:0]        sum_next;
	logic [LEN_W-1:0]        idx_next;
	logic [LEN_W-1:0]        len_eff;
	logic                    accept;
	logic                    window_done;

	// hold off intake while every in-flight beat could still need a queue slot
	assign in_ready = (QUEUE_CNT_W'(q_count) + QUEUE_CNT_W'(v_s1)) < QUEUE_CNT_W'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign prod     = sample * sample;

	always_comb begin
		if (window_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(window_length) > 32'(MAX_WINDOW_LENGTH)) begin
			len_eff = LEN_W'(MAX_WINDOW_LENGTH);
		end else begin
			len_eff = LEN_W'(window_length);
		end
	end

	assign sum_next    = sum_q + SUM_W'(sq_s1);
	assign idx_next    = idx_q + 1'b1;
	assign window_done = v_s1 && (idx_next >= len_eff);

	assign push     = window_done;
	assign push_sum = sum_next;
	assign push_len = len_eff;

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1 <= prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			sum_q <= '0;
			idx_q <= '0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				if (window_done) begin
					sum_q <= '0;
					idx_q <= '0;
				end else begin
					sum_q <= sum_next;
					idx_q <= idx_next;
				end
			end
		end
	end

endmodule

### src/wrdb_back.sv
// Window level unit: iterative decade/tenth log search, peak counting and result register.
module wrdb_back #(
	parameter int MAX_WINDOW_LENGTH = wrdb_pkg::MAX_WINDOW_LENGTH_DEF,
	parameter int LEN_W = $clog2(MAX_WINDOW_LENGTH + 1),
	parameter int SUM_W = wrdb_pkg::SQ_W - 1 + LEN_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  logic [SUM_W-1:0]                   head_sum,
	input  logic [LEN_W-1:0]                   head_len,
	output logic                               pop,
	input  wrdb_pkg::wrdb_frame_cfg_t          frame_cfg,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [wrdb_pkg::DB_W-1:0]   level_db,
	output logic [wrdb_pkg::CNT_W-1:0]         peak_count,
	output logic                               frame_end
);
	import wrdb_pkg::*;

	localparam int HALF   = (SUM_W + 1) / 2;
	localparam int HI_W   = SUM_W - HALF;
	localparam int PROD_W = SUM_W + TP_W;
	localparam int Z_W    = SUM_W + FRAC_SHIFT;
	localparam int T10_W  = SUM_W + 4;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECADE = 3'd1;
	localparam logic [2:0] ST_MUL_LO = 3'd2;
	localparam logic [2:0] ST_MUL_HI = 3'd3;
	localparam logic [2:0] ST_CMP    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]              state_q;
	logic [SUM_W-1:0]        big_q;
	logic [SUM_W-1:0]        t_q;
	logic [DB_W-1:0]         m_q;
	logic [3:0]              i_q;
	logic                    ge_q;
	logic                    zero_q;
	logic [HALF+TP_W-1:0]    lo_q;
	logic [HI_W+TP_W-1:0]    hi_q;

	logic [WPF_W-1:0]        wi_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    prev_loud_q;

	logic                    out_valid_q;
	logic signed [DB_W-1:0]  level_q;
	logic [CNT_W-1:0]        peak_q;
	logic                    frame_end_q;

	logic [T10_W-1:0]        t10;
	logic [TP_W-1:0]         tp;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]       z;
	logic                    head_ge;
	logic                    out_free;
	logic signed [DB_W-1:0]  level;
	logic                    loud;
	logic [CNT_W-1:0]        cnt_new;
	logic [WPF_W-1:0]        wi_next;
	logic [WPF_W-1:0]        wpf_eff;
	logic                    last;

	assign head_ge  = head_sum >= SUM_W'(head_len);
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign out_free = !out_valid_q || out_ready;

	assign t10  = (T10_W'(t_q) << 3) + (T10_W'(t_q) << 1);
	assign tp   = tenth_pow(i_q);
	assign prod = (PROD_W'(hi_q) << HALF) + PROD_W'(lo_q);
	assign z    = PROD_W'({big_q, FRAC_SHIFT'(0)});

	always_comb begin
		if (zero_q) begin
			level = LEVEL_FLOOR;
		end else if (ge_q) begin
			level = (m_q > M_CEIL) ? LEVEL_CEIL : $signed(m_q);
		end else begin
			level = (m_q > M_FLOOR) ? LEVEL_FLOOR : (DB_W'(0) - $signed(m_q));
		end
	end

	assign loud    = level >= frame_cfg.peak_threshold_db;
	assign cnt_new = (loud && !prev_loud_q && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
	assign wpf_eff = (frame_cfg.windows_per_frame == '0) ? WPF_W'(1)
		: frame_cfg.windows_per_frame;
	assign wi_next = wi_q + 1'b1;
	assign last    = wi_next >= wpf_eff;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					big_q  <= head_ge ? head_sum : SUM_W'(head_len);
					t_q    <= head_ge ? SUM_W'(head_len) : head_sum;
					ge_q   <= head_ge;
					zero_q <= head_sum == '0;
					m_q    <= '0;
				end
			end
			ST_DECADE: begin
				if (t10 <= T10_W'(big_q)) begin
					t_q <= t10[SUM_W-1:0];
					m_q <= m_q + DECADE_STEP;
				end else begin
					i_q <= 4'd1;
				end
			end
			ST_MUL_LO: begin
				lo_q <= (HALF+TP_W)'(t_q[HALF-1:0]) * (HALF+TP_W)'(tp);
			end
			ST_MUL_HI: begin
				hi_q <= (HI_W+TP_W)'(t_q[SUM_W-1:HALF]) * (HI_W+TP_W)'(tp);
			end
			ST_CMP: begin
				if (prod <= z) begin
					if (i_q == FRAC_LAST) begin
						m_q <= m_q + DB_W'(FRAC_LAST);
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					m_q <= m_q + DB_W'(i_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			level_q     <= level;
			peak_q      <= cnt_new;
			frame_end_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wi_q        <= '0;
			cnt_q       <= '0;
			prev_loud_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						state_q <= (head_sum == '0) ? ST_DONE : ST_DECADE;
					end
				end
				ST_DECADE: begin
					if (t10 > T10_W'(big_q)) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_CMP;
				ST_CMP: begin
					if (prod <= z && i_q != FRAC_LAST) begin
						state_q <= ST_MUL_LO;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (last) begin
							wi_q        <= '0;
							cnt_q       <= '0;
							prev_loud_q <= 1'b0;
						end else begin
							wi_q        <= wi_next;
							cnt_q       <= cnt_new;
							prev_loud_q <= loud;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign level_db   = level_q;
	assign peak_count = peak_q;
	assign frame_end  = frame_end_q;

endmodule

### src/windowed_rms_db_peak_counter_top.sv
// Top level of the windowed RMS dB level meter with rising-threshold peak counter.
// Samples enter at one beat per clock while in_ready is high; a 16x16 squarer and an
// accumulator close a window after window_length samples and place its sum in a
// four-entry queue. A shared log unit turns each window sum into a dB level by a decade
// search, then tenth steps of low-half multiply, high-half multiply and compare (zero
// energy skips both), then one result beat is offered through an output register.
// Windows shorter than the log time fill the queue and stall intake until the log unit
// catches up; longer windows sustain one sample per cycle while results are taken.
module windowed_rms_db_peak_counter_top #(
	parameter int MAX_WINDOW_LENGTH = wrdb_pkg::MAX_WINDOW_LENGTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wrdb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wrdb_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [wrdb_pkg::SAMPLE_W-1:0]   sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [wrdb_pkg::DB_W-1:0]       level_db,
	output logic [wrdb_pkg::CNT_W-1:0]             peak_count,
	output logic                                   frame_end
);
	import wrdb_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW_LENGTH + 1);
	localparam int SUM_W = SQ_W - 1 + LEN_W;

	logic [WL_W-1:0]         wl_q;
	logic [WPF_W-1:0]        wpf_q;
	logic signed [DB_W-1:0]  thr_q;
	wrdb_frame_cfg_t         frame_cfg;

	logic                    push;
	logic [SUM_W-1:0]        push_sum;
	logic [LEN_W-1:0]        push_len;
	logic                    pop;
	logic                    head_valid;
	logic [SUM_W+LEN_W-1:0]  head_data;
	logic [QUEUE_CNT_W-1:0]  q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= WINDOW_LENGTH_RST;
			wpf_q <= WINDOWS_PER_FRAME_RST;
			thr_q <= PEAK_THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:     wl_q  <= cfg_data[WL_W-1:0];
				REG_WINDOWS_PER_FRAME: wpf_q <= cfg_data[WPF_W-1:0];
				REG_PEAK_THRESHOLD_DB: thr_q <= $signed(cfg_data[DB_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign frame_cfg.windows_per_frame = wpf_q;
	assign frame_cfg.peak_threshold_db = thr_q;

	wrdb_front #(
		.MAX_WINDOW_LENGTH(MAX_WINDOW_LENGTH),
		.LEN_W(LEN_W),
		.SUM_W(SUM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.window_length(wl_q),
		.q_count(q_count),
		.push(push),
		.push_sum(push_sum),
		.push_len(push_len)
	);

	wrdb_queue #(
		.WIDTH(SUM_W + LEN_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_sum, push_len}),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(head_data),
		.count(q_count)
	);

	wrdb_back #(
		.MAX_WINDOW_LENGTH(MAX_WINDOW_LENGTH),
		.LEN_W(LEN_W),
		.SUM_W(SUM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_sum(head_data[SUM_W+LEN_W-1:LEN_W]),
		.head_len(head_data[LEN_W-1:0]),
		.pop(pop),
		.frame_cfg(frame_cfg),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level_db(level_db),
		.peak_count(peak_count),
		.frame_end(frame_end)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("window queue over capacity");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < QUEUE_CNT_W'(QUEUE_DEPTH)))
		else $error("window sum pushed into a full queue");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_db >= LEVEL_FLOOR && level_db <= LEVEL_CEIL))
		else $error("level outside saturation range");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("log unit took an empty queue head");
`endif

endmodule
